@@ rtl/tpmq_pkg.sv @@
// Shared types, codes and defaults of the two-class priority queue bank.
package tpmq_pkg;

    localparam int unsigned NumQueuesDef  = 4;
    localparam int unsigned QueueDepthDef = 16;

    localparam int unsigned FieldW    = 16;
    localparam int unsigned QIdxW     = 2;
    localparam int unsigned CountOutW = 5;
    localparam int unsigned StatusW   = 2;

    localparam logic OpEnq = 1'b0;
    localparam logic OpDeq = 1'b1;

    localparam logic [StatusW-1:0] StOk    = 2'd0;
    localparam logic [StatusW-1:0] StEmpty = 2'd1;
    localparam logic [StatusW-1:0] StFull  = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [QIdxW-1:0]  queue_index;
        logic [FieldW-1:0] service_time;
        logic [FieldW-1:0] volume;
        logic              priority_req;
    } t_in_item;

    typedef struct packed {
        logic [StatusW-1:0]   status;
        logic                 served_valid;
        logic [FieldW-1:0]    served_time;
        logic [FieldW-1:0]    served_volume;
        logic                 served_priority;
        logic [CountOutW-1:0] queue_count;
        logic [QIdxW-1:0]     least_loaded;
    } t_out_item;

    // Command from the sequencer to the queue state
    typedef struct packed {
        logic             exec;
        logic             operation;
        logic             exists;
        logic [QIdxW-1:0] queue_index;
        logic             priority_req;
    } t_qs_cmd;

    // Outcome of the command, valid in the cycle it executes
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic               served;
        logic               served_class;
    } t_qs_rsp;

endpackage

@@ rtl/tpmq_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
interface tpmq_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/tpmq_mem.sv @@
// Entry store: single-port-write, registered-read synchronous memory.
module tpmq_mem #(
    parameter int unsigned DEPTH  = 128,
    parameter int unsigned DATA_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/tpmq_qstate.sv @@
// Per-queue, per-class pointers and counts, with entry store addressing.
module tpmq_qstate #(
    parameter int unsigned NUM_QUEUES  = 4,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  tpmq_pkg::t_qs_cmd                                    i_cmd,
    output tpmq_pkg::t_qs_rsp                                    o_rsp,
    output logic [NUM_QUEUES-1:0][$clog2(QUEUE_DEPTH+1)-1:0]     o_totals,
    output logic                                                 o_wr_en,
    output logic [$clog2(NUM_QUEUES*2*QUEUE_DEPTH)-1:0]          o_wr_addr,
    output logic                                                 o_rd_en,
    output logic [$clog2(NUM_QUEUES*2*QUEUE_DEPTH)-1:0]          o_rd_addr
);
    import tpmq_pkg::*;

    localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned AW = $clog2(NUM_QUEUES * 2 * QUEUE_DEPTH);

    logic [CW-1:0] r_cnt   [NUM_QUEUES][2];
    logic [CW-1:0] r_total [NUM_QUEUES];
    logic [PW-1:0] r_head  [NUM_QUEUES][2];
    logic [PW-1:0] r_tail  [NUM_QUEUES][2];

    logic [QW-1:0] qi;
    logic [CW-1:0] tot;
    logic          cls;
    logic          enq_ok;
    logic          deq_ok;
    logic [PW-1:0] tail;
    logic [PW-1:0] head;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        qi     = i_cmd.exists ? QW'(i_cmd.queue_index) : '0;
        tot    = r_total[qi];
        cls    = (r_cnt[qi][1] != '0);
        enq_ok = i_cmd.exists && (tot < CW'(QUEUE_DEPTH));
        deq_ok = i_cmd.exists && (tot != '0);
        tail   = r_tail[qi][i_cmd.priority_req];
        head   = r_head[qi][cls];

        o_rsp = '0;
        if (i_cmd.operation == OpEnq) begin
            o_rsp.status = enq_ok ? StOk : StFull;
        end else begin
            o_rsp.status       = deq_ok ? StOk : StEmpty;
            o_rsp.served       = deq_ok;
            o_rsp.served_class = cls;
        end

        o_wr_en   = i_cmd.exec && (i_cmd.operation == OpEnq) && enq_ok;
        o_rd_en   = i_cmd.exec && (i_cmd.operation == OpDeq) && deq_ok;
        o_wr_addr = AW'((32'(qi) * 2 + 32'(i_cmd.priority_req)) * QUEUE_DEPTH + 32'(tail));
        o_rd_addr = AW'((32'(qi) * 2 + 32'(cls)) * QUEUE_DEPTH + 32'(head));

        for (int q = 0; q < NUM_QUEUES; q++) begin
            o_totals[q] = r_total[q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_total[q] <= '0;
                for (int c = 0; c < 2; c++) begin
                    r_cnt[q][c]  <= '0;
                    r_head[q][c] <= '0;
                    r_tail[q][c] <= '0;
                end
            end
        end else if (o_wr_en) begin
            r_tail[qi][i_cmd.priority_req] <= ptr_inc(tail);
            r_cnt[qi][i_cmd.priority_req]  <= r_cnt[qi][i_cmd.priority_req] + CW'(1);
            r_total[qi]                    <= tot + CW'(1);
        end else if (o_rd_en) begin
            // serve the priority class first
            r_head[qi][cls] <= ptr_inc(head);
            r_cnt[qi][cls]  <= r_cnt[qi][cls] - CW'(1);
            r_total[qi]     <= tot - CW'(1);
        end
    end
endmodule

@@ rtl/tpmq_scan.sv @@
// Least-loaded search: walks the queue totals one queue per cycle.
module tpmq_scan #(
    parameter int unsigned NUM_QUEUES = 4,
    parameter int unsigned CW         = 5
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic [NUM_QUEUES-1:0][CW-1:0]                         i_totals,
    output logic                                                  o_busy,
    output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] o_best
);
    localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic          r_busy;
    logic [QW-1:0] r_idx;
    logic [QW-1:0] r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_best <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= QW'(1);
            r_best <= '0;
        end else if (r_busy) begin
            // strict compare keeps the lowest index on ties
            if (i_totals[r_idx] < i_totals[r_best]) begin
                r_best <= r_idx;
            end
            if (r_idx == QW'(NUM_QUEUES - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + QW'(1);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_best = r_best;
endmodule

@@ rtl/two_class_priority_multi_queue_unit.sv @@
// Top level of the two-class strict-priority multi-queue bank.
//
//  Channel  Dir  Handshake      Payload
//  i_in     in   valid/ready    tpmq_pkg::t_in_item  (enqueue or serve request)
//  o_out    out  valid/ready    tpmq_pkg::t_out_item (status, served entry, loads)
//
//  A transaction passes through accept, execute (pointer update and entry store
//  access), a least-loaded search over the queue totals (NUM_QUEUES - 1 compares,
//  then a step that sees the search finish), then the result load.
//  Reset clears pointers and counts at once; the entry store is not cleared and
//  only slots written earlier are ever read.
//  A held result stalls the final load; no request is accepted until it is loaded.
module two_class_priority_multi_queue_unit #(
    parameter int unsigned NUM_QUEUES  = tpmq_pkg::NumQueuesDef,
    parameter int unsigned QUEUE_DEPTH = tpmq_pkg::QueueDepthDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tpmq_stream_if.sink    i_in,
    tpmq_stream_if.source  o_out
);
    import tpmq_pkg::*;

    localparam int unsigned QW       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MemDepth = NUM_QUEUES * 2 * QUEUE_DEPTH;
    localparam int unsigned AW       = $clog2(MemDepth);
    localparam int unsigned DataW    = 2 * FieldW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    t_in_item        r_item;
    logic            r_exists;
    t_qs_rsp         r_rsp;
    logic            r_out_valid;
    t_out_item       r_out;
    t_out_item       n_out;

    t_qs_cmd                      qs_cmd;
    t_qs_rsp                      qs_rsp;
    logic [NUM_QUEUES-1:0][CW-1:0] totals;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [DataW-1:0]             rd_data;
    logic                         scan_busy;
    logic [QW-1:0]                scan_best;
    logic                         load_out;
    logic [QW-1:0]                qi;
    logic [31:0]                  cnt32;
    logic [31:0]                  best32;

    tpmq_qstate #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qstate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (qs_cmd),
        .o_rsp     (qs_rsp),
        .o_totals  (totals),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    tpmq_mem #(
        .DEPTH  (MemDepth),
        .DATA_W (DataW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_item.service_time, r_item.volume}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tpmq_scan #(
        .NUM_QUEUES (NUM_QUEUES),
        .CW         (CW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_EXEC),
        .i_totals (totals),
        .o_busy   (scan_busy),
        .o_best   (scan_best)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        qs_cmd              = '0;
        qs_cmd.exec         = (r_state == S_EXEC);
        qs_cmd.operation    = r_item.operation;
        qs_cmd.exists       = r_exists;
        qs_cmd.queue_index  = r_item.queue_index;
        qs_cmd.priority_req = r_item.priority_req;

        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_EXEC;
            S_EXEC: n_state = S_SCAN;
            S_SCAN: if (!scan_busy) n_state = S_DONE;
            S_DONE: if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        qi     = r_exists ? QW'(r_item.queue_index) : '0;
        cnt32  = r_exists ? 32'(totals[qi]) : '0;
        best32 = 32'(scan_best);

        n_out                 = '0;
        n_out.status          = r_rsp.status;
        n_out.served_valid    = r_rsp.served;
        n_out.served_time     = r_rsp.served ? rd_data[DataW-1:FieldW] : '0;
        n_out.served_volume   = r_rsp.served ? rd_data[FieldW-1:0] : '0;
        n_out.served_priority = r_rsp.served & r_rsp.served_class;
        n_out.queue_count     = cnt32[CountOutW-1:0];
        n_out.least_loaded    = best32[QIdxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item   <= i_in.payload;
            r_exists <= (32'(i_in.payload.queue_index) < NUM_QUEUES);
        end
        if (r_state == S_EXEC) begin
            r_rsp <= qs_rsp;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    a_served_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.served_valid |-> o_out.payload.status == StOk)
        else $error("served entry reported with a failure status");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> 32'(o_out.payload.queue_count) <= QUEUE_DEPTH)
        else $error("queue count beyond queue depth");

    a_scan_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !scan_busy)
        else $error("result loaded before least-loaded search finished");

    a_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("entry store written and read in one cycle");
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the two-class priority multi-queue bank.
module tb_top;
    import tpmq_pkg::*;

    localparam int unsigned NumQ    = NumQueuesDef;
    localparam int unsigned Depth   = QueueDepthDef;
    localparam int unsigned DirRows = 26;
    localparam int unsigned RandItems = 625;
    localparam int unsigned Latency = NumQueuesDef + 3;

    typedef struct {
        t_in_item  item;
        bit        has_want;
        t_out_item want;
    } dir_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tpmq_stream_if #(.t_payload(t_in_item))  in_ch ();
    tpmq_stream_if #(.t_payload(t_out_item)) out_ch ();

    two_class_priority_multi_queue_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the queue bank
    logic [FieldW-1:0] slot_time [NumQ][2][Depth];
    logic [FieldW-1:0] slot_vol  [NumQ][2][Depth];
    int unsigned       rd_ptr    [NumQ][2];
    int unsigned       wr_ptr    [NumQ][2];
    int unsigned       held      [NumQ][2];

    t_out_item   pending_results [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned requests_sent;
    int unsigned drops_seen;
    int unsigned empties_seen;
    int unsigned serves_seen;
    int unsigned peak_fill;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advance the shadow bank by one request and return the result it must produce
    function automatic t_out_item bank_step(t_in_item it);
        t_out_item   r;
        int unsigned qi;
        int unsigned cl;
        int unsigned tot;
        int unsigned best;
        int unsigned best_n;
        r   = '0;
        qi  = 32'(it.queue_index);
        tot = held[qi][0] + held[qi][1];
        if (it.operation == OpEnq) begin
            if (tot >= Depth) begin
                r.status = StFull;
                drops_seen++;
            end else begin
                cl = 32'(it.priority_req);
                slot_time[qi][cl][wr_ptr[qi][cl]] = it.service_time;
                slot_vol[qi][cl][wr_ptr[qi][cl]]  = it.volume;
                wr_ptr[qi][cl] = (wr_ptr[qi][cl] + 1) % Depth;
                held[qi][cl]++;
            end
        end else begin
            if (tot == 0) begin
                r.status = StEmpty;
                empties_seen++;
            end else begin
                // Priority class drains first
                cl = (held[qi][1] != 0) ? 1 : 0;
                r.served_valid    = 1'b1;
                r.served_time     = slot_time[qi][cl][rd_ptr[qi][cl]];
                r.served_volume   = slot_vol[qi][cl][rd_ptr[qi][cl]];
                r.served_priority = (cl == 1);
                rd_ptr[qi][cl] = (rd_ptr[qi][cl] + 1) % Depth;
                held[qi][cl]--;
                serves_seen++;
            end
        end
        tot = held[qi][0] + held[qi][1];
        if (tot > peak_fill) peak_fill = tot;
        r.queue_count = CountOutW'(tot);
        best   = 0;
        best_n = held[0][0] + held[0][1];
        for (int q = 1; q < NumQ; q++) begin
            if (held[q][0] + held[q][1] < best_n) begin
                best   = q;
                best_n = held[q][0] + held[q][1];
            end
        end
        r.least_loaded = QIdxW'(best);
        return r;
    endfunction

    function automatic t_in_item mk_item(logic op, int unsigned q, logic [FieldW-1:0] t,
                                         logic [FieldW-1:0] v, logic pr);
        t_in_item it;
        it.operation    = op;
        it.queue_index  = QIdxW'(q);
        it.service_time = t;
        it.volume       = v;
        it.priority_req = pr;
        return it;
    endfunction

    // Result of a request that serves nothing
    function automatic t_out_item plain_result(logic [StatusW-1:0] st, int unsigned cnt,
                                               int unsigned least);
        t_out_item r;
        r              = '0;
        r.status       = st;
        r.queue_count  = CountOutW'(cnt);
        r.least_loaded = QIdxW'(least);
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FieldW-1:0] draw_field();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FieldW'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Offer one transaction, hold it until accepted, then log its expected result
    task automatic send_item(t_in_item it, bit has_want, t_out_item want);
        t_out_item pred;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = bank_step(it);
        pending_results.push_back(has_want ? want : pred);
        requests_sent++;
    endtask

    task automatic idle_input(int unsigned n);
        logic [63:0] junk;
        if (n == 0) return;
        junk = {$urandom, $urandom};
        in_ch.valid   <= 1'b0;
        in_ch.payload <= junk[$bits(t_in_item)-1:0];
        repeat (n) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, actual %p",
                         $time, out_ch.payload);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, out_ch.payload.status);
                check_field("served_valid", want.served_valid, out_ch.payload.served_valid);
                check_field("served_time", want.served_time, out_ch.payload.served_time);
                check_field("served_volume", want.served_volume,
                            out_ch.payload.served_volume);
                check_field("served_priority", want.served_priority,
                            out_ch.payload.served_priority);
                check_field("queue_count", want.queue_count, out_ch.payload.queue_count);
                check_field("least_loaded", want.least_loaded, out_ch.payload.least_loaded);
            end
        end
    end

    initial begin : result_sink
        int unsigned n;
        bit          held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= 200) begin
                // Long hold-off so the bank backs up and stalls its input
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if ($urandom_range(0, 39) == 0) begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            end else begin
                n = draw_gap();
                if (n != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        dir_row_t    dir_rows [DirRows];
        t_in_item    it;
        int unsigned enq_pct;
        int          focus;
        bit          calm;
        int unsigned wait_cycles;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        dir_rows[0] = '{mk_item(OpDeq, 0, '0, '0, 1'b0), 1'b1, plain_result(StEmpty, 0, 0)};
        dir_rows[1] = '{mk_item(OpEnq, 1, '1, '0, 1'b0), 1'b1, plain_result(StOk, 1, 0)};
        dir_rows[2] = '{mk_item(OpEnq, 1, '0, '1, 1'b1), 1'b0, '0};
        dir_rows[3] = '{mk_item(OpEnq, 1, 16'h8001, 16'h7FFE, 1'b0), 1'b0, '0};
        // Priority entry jumps the two normal ones
        dir_rows[4] = '{mk_item(OpDeq, 1, '0, '0, 1'b0), 1'b0, '0};
        dir_rows[5] = '{mk_item(OpDeq, 1, '0, '0, 1'b1), 1'b0, '0};
        dir_rows[6] = '{mk_item(OpDeq, 1, '1, '1, 1'b0), 1'b0, '0};
        dir_rows[7] = '{mk_item(OpDeq, 1, '0, '0, 1'b0), 1'b1, plain_result(StEmpty, 0, 0)};
        // Fill queue 3 with a mix of classes
        for (int i = 0; i < Depth; i++) begin
            dir_rows[8 + i] = '{mk_item(OpEnq, 3, FieldW'(i * 16'h1111), ~FieldW'(i * 16'h1111),
                                        (i % 3) == 0), 1'b0, '0};
        end
        dir_rows[24] = '{mk_item(OpEnq, 3, '1, '1, 1'b1), 1'b1, plain_result(StFull, Depth, 0)};
        dir_rows[25] = '{mk_item(OpDeq, 3, '0, '0, 1'b0), 1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DirRows; i++) begin
            send_item(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);
            idle_input(draw_gap());
        end

        enq_pct = 50;
        focus   = -1;
        calm    = 1'b0;
        for (int n = 0; n < RandItems; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 4))
                    0:       enq_pct = 85;
                    1:       enq_pct = 70;
                    2:       enq_pct = 50;
                    3:       enq_pct = 30;
                    default: enq_pct = 15;
                endcase
                focus = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, NumQ - 1)) : -1;
                calm  = ($urandom_range(0, 3) == 0);
            end
            if (n == 300) begin
                // Pause until the bank has delivered everything outstanding
                idle_input(1);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            it.operation    = ($urandom_range(0, 99) < enq_pct) ? OpEnq : OpDeq;
            it.queue_index  = (focus >= 0 && $urandom_range(0, 3) != 0) ?
                              QIdxW'(focus) : QIdxW'($urandom_range(0, NumQ - 1));
            it.service_time = draw_field();
            it.volume       = draw_field();
            it.priority_req = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, '0);
            idle_input(calm ? 0 : draw_gap());
        end
        idle_input(1);

        while (pending_results.size() != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 4 * Latency) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("Sent %0d requests, compared %0d results: %0d serves, %0d drops on a full queue,",
                 requests_sent, results_seen, serves_seen, drops_seen);
        $display("%0d serves from an empty queue, deepest queue held %0d entries",
                 empties_seen, peak_fill);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tpmq_pkg.sv
rtl/tpmq_stream_if.sv
rtl/tpmq_mem.sv
rtl/tpmq_qstate.sv
rtl/tpmq_scan.sv
rtl/two_class_priority_multi_queue_unit.sv
test/tb_top.sv
